[rtl/core/bdq_pkg.sv]
package bdq_pkg;

	// default number of cells in the chain
	localparam int unsigned DEPTH_DEF = 16;

	// field widths
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned LIMIT_W = 5;

	// capacity register value after reset
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	// word reported at both ends when the queue is empty
	localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH_FRONT = 2'd0,
		FUNC_PUSH_BACK  = 2'd1,
		FUNC_POP_FRONT  = 2'd2,
		FUNC_POP_BACK   = 2'd3
	} func_t;

	// input item
	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [WORD_W-1:0] push_word;
	} in_item_t;

	// result item
	typedef struct packed {
		logic                     ok;
		logic signed [WORD_W-1:0] front_word;
		logic signed [WORD_W-1:0] rear_word;
		logic                     is_empty;
		logic                     is_full;
	} out_item_t;

	// command broadcast to every cell, at most one flag set
	typedef struct packed {
		logic shift_back;  // push front: take the word from the front-side neighbor
		logic shift_front; // pop front: take the word from the rear-side neighbor
		logic append;      // push back: the cell just past the rear loads the new word
	} cell_cmd_t;

endpackage

[rtl/core/bounded_double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit words, built as a chain of DEPTH word cells
// with the front entry always in cell 0. Each item is one of push front, push back, pop
// front or pop back and gives exactly one result: ok, the front and rear words after the
// operation (all ones when empty), is_empty and is_full. A push into a full queue and a pop
// from an empty one fail and change nothing. The cells shift or load in the cycle the
// item is accepted, and the result register samples the updated chain once the output
// is free. The queue is full at min(capacity_limit, DEPTH) entries; lowering the
// limit below the current count drops nothing. Write capacity_limit only while idle.
module bounded_double_ended_queue #(
	parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  bdq_pkg::in_item_t                  in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output bdq_pkg::out_item_t                 out_item,
	input  logic                               cfg_we,
	input  logic [bdq_pkg::LIMIT_W-1:0]        cfg_wdata
);
	import bdq_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	logic [LIMIT_W-1:0]       limit_q;
	logic [CNT_W-1:0]         count_q;
	logic                     pend_q;
	logic                     ok_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     op_ok;
	cell_cmd_t                cmd;
	logic [CNT_W-1:0]         count_nxt;
	logic                     out_load;
	logic signed [WORD_W-1:0] cell_word [DEPTH];
	logic signed [WORD_W-1:0] cell_tap  [DEPTH];
	logic signed [WORD_W-1:0] rear_sel;

	// handshake: one item in flight between the chain and the result register
	assign accept   = in_valid && !in_stall;
	assign in_stall = pend_q || (out_valid_q && out_stall);
	assign out_load = pend_q && (!out_valid_q || !out_stall);

	// occupancy flags of the current chain
	assign full  = (CMP_W'(count_q) >= CMP_W'(limit_q)) || (CMP_W'(count_q) >= CMP_W'(DEPTH));
	assign empty = (count_q == '0);

	// decode the operation into a chain command and the new count
	always_comb begin
		op_ok     = 1'b0;
		cmd       = '0;
		count_nxt = count_q;
		unique case (func_t'(in_item.func))
			FUNC_PUSH_FRONT: begin
				op_ok          = !full;
				cmd.shift_back = accept && !full;
				if (!full) count_nxt = count_q + CNT_W'(1);
			end
			FUNC_PUSH_BACK: begin
				op_ok      = !full;
				cmd.append = accept && !full;
				if (!full) count_nxt = count_q + CNT_W'(1);
			end
			FUNC_POP_FRONT: begin
				op_ok           = !empty;
				cmd.shift_front = accept && !empty;
				if (!empty) count_nxt = count_q - CNT_W'(1);
			end
			FUNC_POP_BACK: begin
				op_ok = !empty;
				if (!empty) count_nxt = count_q - CNT_W'(1);
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	// chain of word cells, front entry in cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] prev_w;
		logic signed [WORD_W-1:0] next_w;
		if (i == 0) begin : g_first
			assign prev_w = in_item.push_word;
		end else begin : g_mid
			assign prev_w = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_w = cell_word[i];
		end else begin : g_inner
			assign next_w = cell_word[i+1];
		end
		bdq_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count_q),
			.prev_word (prev_w),
			.next_word (next_w),
			.push_word (in_item.push_word),
			.word      (cell_word[i]),
			.rear_tap  (cell_tap[i])
		);
	end

	// gather the rear word, only the rear cell drives a nonzero tap
	always_comb begin
		rear_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_sel = rear_sel | cell_tap[i];
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// count and in-flight flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (accept) count_q <= count_nxt;
			if (accept) begin
				pend_q <= 1'b1;
			end else if (out_load) begin
				pend_q <= 1'b0;
			end
		end
	end

	// ok flag held until the result is built
	always_ff @(posedge clk) begin
		if (accept) ok_q <= op_ok;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.ok         <= ok_q;
			out_q.front_word <= empty ? EMPTY_WORD : cell_word[0];
			out_q.rear_word  <= empty ? EMPTY_WORD : rear_sel;
			out_q.is_empty   <= empty;
			out_q.is_full    <= full;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	// the count never runs past the chain length
	assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(DEPTH))
		else $error("entry count above depth");

	// the count moves only on an accepted item
	assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count changed without an item");

	// an empty result shows all ones at both ends
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.is_empty |->
		out_q.front_word == EMPTY_WORD && out_q.rear_word == EMPTY_WORD)
		else $error("empty result with stale words");

	// after an accepted item the in-flight flag is set and no second item is accepted in the cycle after
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pend_q && !accept)
		else $error("second item accepted while one is in flight");
`endif

endmodule

[rtl/core/bdq_cell.sv]
module bdq_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned CNT_W = 5
) (
	input  logic                              clk,
	input  bdq_pkg::cell_cmd_t                cmd,
	input  logic [CNT_W-1:0]                  count,
	input  logic signed [bdq_pkg::WORD_W-1:0] prev_word,
	input  logic signed [bdq_pkg::WORD_W-1:0] next_word,
	input  logic signed [bdq_pkg::WORD_W-1:0] push_word,
	output logic signed [bdq_pkg::WORD_W-1:0] word,
	output logic signed [bdq_pkg::WORD_W-1:0] rear_tap
);
	import bdq_pkg::*;

	logic signed [WORD_W-1:0] word_q;
	logic                     at_tail;
	logic                     at_rear;

	// position of this cell relative to the occupied prefix
	assign at_tail = (count == CNT_W'(IDX));
	assign at_rear = (count == CNT_W'(IDX + 1));

	// word storage, moved along the chain by the broadcast command
	always_ff @(posedge clk) begin
		priority if (cmd.shift_back) begin
			word_q <= prev_word;
		end else if (cmd.shift_front) begin
			word_q <= next_word;
		end else if (cmd.append && at_tail) begin
			word_q <= push_word;
		end else begin
			word_q <= word_q;
		end
	end

	assign word     = word_q;
	assign rear_tap = at_rear ? word_q : '0;

endmodule
